// File: hdl/cbez_pkg.sv
`timescale 1ns / 1ps
package cbez_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 15;
    localparam int T_W        = FRAC_BITS + 1;
    localparam int T3_W       = FRAC_BITS + 2;
    localparam int SQ_W       = 2 * FRAC_BITS + 1;
    localparam int WGT_W      = 3 * FRAC_BITS + 1;
    localparam int PROD_W     = WGT_W + COORD_BITS + 1;
    localparam int SUM_W      = PROD_W + 2;
    localparam int NUM_REGS   = 8;
    localparam int IDX_W      = $clog2(NUM_REGS);
    localparam int ADDR_W     = IDX_W + 2;
    localparam int DATA_W     = 32;

    localparam logic [T_W-1:0]   T_ONE = T_W'(1) << FRAC_BITS;
    localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (3 * FRAC_BITS - 1);

    typedef enum logic [IDX_W-1:0] {
        REG_P0_X,
        REG_P0_Y,
        REG_P1_X,
        REG_P1_Y,
        REG_P2_X,
        REG_P2_Y,
        REG_P3_X,
        REG_P3_Y
    } reg_idx_t;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [WGT_W-1:0] wgt_t;

    typedef struct packed {
        coord_t [3:0] px;
        coord_t [3:0] py;
    } ctrl_t;

    typedef struct packed {
        logic          valid;
        wgt_t  [3:0]   w;
    } wgt_bus_t;

endpackage

// File: hdl/cubic_bezier_point_eval.sv
`timescale 1ns / 1ps
// A param_t transfer loads the first of six register stages; the curve
// point is presented from the last. Throughput: one point per cycle
// when curve_stall is low; the stages (clamp, squares, cubic weights,
// weighted points, pair sums, round) each hold one item.
// Reset: rst_n clears all valid bits and sets every control point to zero.
module cubic_bezier_point_eval
    import cbez_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              param_valid,
    output logic              param_stall,
    input  logic [T_W-1:0]    param_t,
    output logic              curve_valid,
    input  logic              curve_stall,
    output coord_t            curve_x,
    output coord_t            curve_y
);

    ctrl_t    ctrl;
    wgt_bus_t wgt;
    logic     blend_ready;

    cbez_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .ctrl    (ctrl)
    );

    cbez_weights u_weights (
        .clk         (clk),
        .rst_n       (rst_n),
        .param_valid (param_valid),
        .param_t     (param_t),
        .param_stall (param_stall),
        .dn_ready    (blend_ready),
        .wgt         (wgt)
    );

    cbez_blend u_blend (
        .clk         (clk),
        .rst_n       (rst_n),
        .wgt         (wgt),
        .up_ready    (blend_ready),
        .ctrl        (ctrl),
        .curve_valid (curve_valid),
        .curve_stall (curve_stall),
        .curve_x     (curve_x),
        .curve_y     (curve_y)
    );

endmodule

// File: hdl/cbez_regs.sv
`timescale 1ns / 1ps
module cbez_regs
    import cbez_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output ctrl_t             ctrl
);

    coord_t           cfg_reg [NUM_REGS];
    logic [IDX_W-1:0] idx;
    logic             wr_en;

    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = DATA_W'(cfg_reg[idx]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                cfg_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            cfg_reg[idx] <= pwdata[COORD_BITS-1:0];
        end
    end

    assign ctrl.px[0] = cfg_reg[REG_P0_X];
    assign ctrl.py[0] = cfg_reg[REG_P0_Y];
    assign ctrl.px[1] = cfg_reg[REG_P1_X];
    assign ctrl.py[1] = cfg_reg[REG_P1_Y];
    assign ctrl.px[2] = cfg_reg[REG_P2_X];
    assign ctrl.py[2] = cfg_reg[REG_P2_Y];
    assign ctrl.px[3] = cfg_reg[REG_P3_X];
    assign ctrl.py[3] = cfg_reg[REG_P3_Y];

endmodule

// File: hdl/cbez_weights.sv
`timescale 1ns / 1ps
module cbez_weights
    import cbez_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           param_valid,
    input  logic [T_W-1:0] param_t,
    output logic           param_stall,
    input  logic           dn_ready,
    output wgt_bus_t       wgt
);

    // stage A: clamp and complement
    logic            a_valid_reg;
    logic [T_W-1:0]  a_t_reg, a_t_next;
    logic [T_W-1:0]  a_u_reg, a_u_next;
    logic [T3_W-1:0] a_t3_reg, a_t3_next;
    // stage B: squares and cross term
    logic            b_valid_reg;
    logic [T_W-1:0]  b_t_reg, b_u_reg;
    logic [SQ_W-1:0] b_t2_reg, b_t2_next;
    logic [SQ_W-1:0] b_u2_reg, b_u2_next;
    logic [SQ_W-1:0] b_tu3_reg, b_tu3_next;
    // stage C: cubic weights
    logic            c_valid_reg;
    wgt_t [3:0]      c_w_reg, c_w_next;

    logic a_ready, b_ready, c_ready;

    assign c_ready = !c_valid_reg || dn_ready;
    assign b_ready = !b_valid_reg || c_ready;
    assign a_ready = !a_valid_reg || b_ready;
    assign param_stall = !a_ready;

    always_comb
    begin
        a_t_next  = (param_t > T_ONE) ? T_ONE : param_t;
        a_u_next  = T_ONE - a_t_next;
        a_t3_next = T3_W'(a_t_next) + {a_t_next, 1'b0};
        b_t2_next  = SQ_W'(a_t_reg * a_t_reg);
        b_u2_next  = SQ_W'(a_u_reg * a_u_reg);
        b_tu3_next = SQ_W'(a_t3_reg * a_u_reg);
        c_w_next[0] = WGT_W'(b_u2_reg * b_u_reg);
        c_w_next[1] = WGT_W'(b_tu3_reg * b_u_reg);
        c_w_next[2] = WGT_W'(b_tu3_reg * b_t_reg);
        c_w_next[3] = WGT_W'(b_t2_reg * b_t_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= param_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && param_valid)
        begin
            a_t_reg  <= a_t_next;
            a_u_reg  <= a_u_next;
            a_t3_reg <= a_t3_next;
        end
        if (b_ready && a_valid_reg)
        begin
            b_t_reg   <= a_t_reg;
            b_u_reg   <= a_u_reg;
            b_t2_reg  <= b_t2_next;
            b_u2_reg  <= b_u2_next;
            b_tu3_reg <= b_tu3_next;
        end
        if (c_ready && b_valid_reg)
        begin
            c_w_reg <= c_w_next;
        end
    end

    assign wgt.valid = c_valid_reg;
    assign wgt.w     = c_w_reg;

endmodule

// File: hdl/cbez_blend.sv
`timescale 1ns / 1ps
module cbez_blend
    import cbez_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  wgt_bus_t wgt,
    output logic     up_ready,
    input  ctrl_t    ctrl,
    output logic     curve_valid,
    input  logic     curve_stall,
    output coord_t   curve_x,
    output coord_t   curve_y
);

    // stage D: weighted control points
    logic                     d_valid_reg;
    logic signed [PROD_W-1:0] d_px_reg [4];
    logic signed [PROD_W-1:0] d_py_reg [4];
    logic signed [PROD_W-1:0] d_px_next [4];
    logic signed [PROD_W-1:0] d_py_next [4];
    // stage E: pair sums
    logic                     e_valid_reg;
    logic signed [SUM_W-1:0]  e_x01_reg, e_x23_reg, e_y01_reg, e_y23_reg;
    logic signed [SUM_W-1:0]  e_x01_next, e_x23_next, e_y01_next, e_y23_next;
    // stage F: round and hold for the transfer
    logic                     f_valid_reg;
    logic signed [SUM_W-1:0]  f_x_sum, f_y_sum;
    coord_t                   f_x_reg, f_y_reg;

    logic d_ready, e_ready, f_ready;

    assign f_ready  = !f_valid_reg || !curve_stall;
    assign e_ready  = !e_valid_reg || f_ready;
    assign d_ready  = !d_valid_reg || e_ready;
    assign up_ready = d_ready;

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            d_px_next[j] = $signed({1'b0, wgt.w[j]}) * $signed(ctrl.px[j]);
            d_py_next[j] = $signed({1'b0, wgt.w[j]}) * $signed(ctrl.py[j]);
        end
        e_x01_next = SUM_W'(d_px_reg[0]) + SUM_W'(d_px_reg[1]);
        e_x23_next = SUM_W'(d_px_reg[2]) + SUM_W'(d_px_reg[3]);
        e_y01_next = SUM_W'(d_py_reg[0]) + SUM_W'(d_py_reg[1]);
        e_y23_next = SUM_W'(d_py_reg[2]) + SUM_W'(d_py_reg[3]);
        f_x_sum = e_x01_reg + e_x23_reg + $signed(ROUND_HALF);
        f_y_sum = e_y01_reg + e_y23_reg + $signed(ROUND_HALF);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end
        else
        begin
            if (d_ready)
            begin
                d_valid_reg <= wgt.valid;
            end
            if (e_ready)
            begin
                e_valid_reg <= d_valid_reg;
            end
            if (f_ready)
            begin
                f_valid_reg <= e_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_ready && wgt.valid)
        begin
            d_px_reg <= d_px_next;
            d_py_reg <= d_py_next;
        end
        if (e_ready && d_valid_reg)
        begin
            e_x01_reg <= e_x01_next;
            e_x23_reg <= e_x23_next;
            e_y01_reg <= e_y01_next;
            e_y23_reg <= e_y23_next;
        end
        if (f_ready && e_valid_reg)
        begin
            f_x_reg <= f_x_sum[3*FRAC_BITS +: COORD_BITS];
            f_y_reg <= f_y_sum[3*FRAC_BITS +: COORD_BITS];
        end
    end

    assign curve_valid = f_valid_reg;
    assign curve_x     = f_x_reg;
    assign curve_y     = f_y_reg;

endmodule

// File: hdl/cbez_checker.sv
`timescale 1ns / 1ps
module cbez_checker
    import cbez_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic [DATA_W-1:0] prdata,
    input  logic              pready,
    input  logic              param_stall,
    input  logic              curve_valid,
    input  logic              curve_stall,
    input  coord_t            curve_x,
    input  coord_t            curve_y
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        curve_valid && curve_stall |=> curve_valid && $stable(curve_x) && $stable(curve_y))
        else $error("curve point changed while stalled");

    a_stall_backed: assert property (@(posedge clk) disable iff (!rst_n)
        param_stall |-> curve_valid && curve_stall)
        else $error("input stalled with output free");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

    a_readback: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) && $past(psel && penable && pwrite) && paddr == $past(paddr)
        |-> prdata == DATA_W'($signed($past(pwdata[COORD_BITS-1:0]))))
        else $error("register readback mismatch");

endmodule

bind cubic_bezier_point_eval cbez_checker u_cbez_checker (.*);
